// ===== sv/acp_pkg.sv =====
// Shared types and constants for the ASCII to unsigned parser.
package acp_pkg;

    localparam longint unsigned DEF_MAX_LEN     = 64'd65535;
    localparam int              DEF_QUEUE_DEPTH = 2;
    localparam int              DEF_RES_DEPTH   = 2;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] BASE_HEX    = 6'd16;
    localparam logic [5:0] BASE_OCT    = 6'd8;
    localparam logic [5:0] BASE_DEC    = 6'd10;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    typedef enum logic [2:0] {
        PH_WS,
        PH_SIGNED,
        PH_ZERO,
        PH_HEXX,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    // Classified character as it travels from front to back.
    typedef struct packed {
        logic       start;
        logic       nul;
        logic       space;
        logic       sign;
        logic       minus;
        logic       zero_ch;
        logic       x_ch;
        logic       dig_ok;
        logic [5:0] dig;
    } t_cls;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] end_offset;
        logic        overflow;
        logic        no_digits;
    } t_res;

endpackage

// ===== sv/acp_fifo.sv =====
// Small first-in first-out queue of flip-flops with full and empty flags.
module acp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== sv/acp_front.sv =====
// Front end: accepts characters and classifies them for the parse engine.
module acp_front (
    input  logic          i_ch_push,
    input  logic [7:0]    i_ch,
    input  logic          i_start_of_string,
    input  logic          i_q_full,
    output logic          o_ch_full,
    output logic          o_q_push,
    output acp_pkg::t_cls o_cls
);
    import acp_pkg::*;

    assign o_ch_full = i_q_full;
    assign o_q_push  = i_ch_push && !i_q_full;

    always_comb begin
        o_cls         = '0;
        o_cls.start   = i_start_of_string;
        o_cls.nul     = (i_ch == CH_NUL);
        o_cls.space   = (i_ch == CH_SPACE) || ((i_ch >= CH_TAB) && (i_ch <= CH_CR));
        o_cls.sign    = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);
        o_cls.minus   = (i_ch == CH_MINUS);
        o_cls.zero_ch = (i_ch == CH_ZERO);
        o_cls.x_ch    = (i_ch == CH_LO_X) || (i_ch == CH_UP_X);
        // Map digits and letters to their values, letters from ten up.
        if ((i_ch >= CH_ZERO) && (i_ch <= CH_NINE)) begin
            o_cls.dig_ok = 1'b1;
            o_cls.dig    = 6'(i_ch - CH_ZERO);
        end else if ((i_ch >= CH_UP_A) && (i_ch <= CH_UP_Z)) begin
            o_cls.dig_ok = 1'b1;
            o_cls.dig    = 6'(i_ch - CH_UP_A + 8'd10);
        end else if ((i_ch >= CH_LO_A) && (i_ch <= CH_LO_Z)) begin
            o_cls.dig_ok = 1'b1;
            o_cls.dig    = 6'(i_ch - CH_LO_A + 8'd10);
        end
    end

endmodule

// ===== sv/acp_back.sv =====
// Parse engine: runs the prefix state machine and the multiply-add accumulator.
module acp_back #(
    parameter longint unsigned P_MAX_LEN = acp_pkg::DEF_MAX_LEN
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [5:0]    i_radix,
    input  logic          i_q_empty,
    input  acp_pkg::t_cls i_cls,
    output logic          o_q_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output acp_pkg::t_res o_res
);
    import acp_pkg::*;

    localparam int POS_W = $clog2(P_MAX_LEN + 64'd1);

    t_phase            r_phase, n_phase, ph_e;
    logic [63:0]       r_acc, n_acc, acc_e;
    logic              r_neg, n_neg, neg_e;
    logic [5:0]        r_base, n_base, base_e;
    logic [POS_W-1:0]  r_pos, n_pos, pos_e;
    logic              r_seen, n_seen, seen_e;

    logic              do_step;
    logic              emit;
    logic [5:0]        step_base;
    logic [69:0]       prod;
    logic [64:0]       sum;
    logic              stop;
    logic [63:0]       mag;

    assign o_q_pop = !i_q_empty && !i_res_full;

    always_comb begin
        // Start flag restarts the parse before the character is taken.
        ph_e   = i_cls.start ? PH_WS : r_phase;
        acc_e  = i_cls.start ? '0 : r_acc;
        neg_e  = i_cls.start ? 1'b0 : r_neg;
        base_e = i_cls.start ? '0 : r_base;
        pos_e  = i_cls.start ? '0 : r_pos;
        seen_e = i_cls.start ? 1'b0 : r_seen;

        n_phase   = ph_e;
        n_acc     = acc_e;
        n_neg     = neg_e;
        n_base    = base_e;
        n_seen    = seen_e;
        n_pos     = (pos_e < POS_W'(P_MAX_LEN)) ? pos_e + 1'b1 : pos_e;
        do_step   = 1'b0;
        step_base = base_e;
        emit      = 1'b0;
        o_res     = '0;

        case (ph_e)
            PH_WS, PH_SIGNED: begin
                if (ph_e == PH_WS && i_cls.space) begin
                    n_phase = PH_WS;
                end else if (ph_e == PH_WS && i_cls.sign) begin
                    n_base  = i_radix;
                    n_neg   = i_cls.minus;
                    n_phase = PH_SIGNED;
                end else begin
                    step_base = (ph_e == PH_WS) ? i_radix : base_e;
                    if (step_base == '0 && i_cls.zero_ch) begin
                        n_base  = step_base;
                        n_seen  = 1'b1;
                        n_acc   = '0;
                        n_phase = PH_ZERO;
                    end else begin
                        if (step_base == '0) begin
                            step_base = BASE_DEC;
                        end
                        n_base  = step_base;
                        n_phase = PH_DIGITS;
                        do_step = 1'b1;
                    end
                end
            end
            PH_ZERO: begin
                if (i_cls.x_ch) begin
                    n_base  = BASE_HEX;
                    n_phase = PH_HEXX;
                end else begin
                    step_base = BASE_OCT;
                    n_base    = BASE_OCT;
                    n_phase   = PH_DIGITS;
                    do_step   = 1'b1;
                end
            end
            PH_HEXX: begin
                if (!i_cls.nul && i_cls.dig_ok && (i_cls.dig < BASE_HEX)) begin
                    n_phase = PH_DIGITS;
                    do_step = 1'b1;
                end else begin
                    // Prefix without a hex digit: the parse ends at the x.
                    emit             = 1'b1;
                    o_res.end_offset = 16'((pos_e != '0) ? pos_e - 1'b1 : pos_e);
                end
            end
            PH_DIGITS: begin
                do_step = 1'b1;
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        prod = acc_e * step_base;
        sum  = {1'b0, prod[63:0]} + 65'(i_cls.dig);
        stop = i_cls.nul || (step_base == '0) || !i_cls.dig_ok || (i_cls.dig >= step_base);

        mag = acc_e;
        if (neg_e) begin
            if (acc_e[63]) begin
                mag = (acc_e[62:0] == '0) ? acc_e : '0;
            end else begin
                mag = '0 - acc_e;
            end
        end

        if (do_step) begin
            if (stop) begin
                emit = 1'b1;
                if (!seen_e) begin
                    o_res.no_digits = 1'b1;
                end else begin
                    o_res.value      = mag;
                    o_res.end_offset = 16'(pos_e);
                end
            end else if ((prod[69:64] != '0) || sum[64]) begin
                emit             = 1'b1;
                o_res.value      = '1;
                o_res.end_offset = 16'(pos_e);
                o_res.overflow   = 1'b1;
            end else begin
                n_acc  = sum[63:0];
                n_seen = 1'b1;
            end
        end

        if (emit) begin
            n_phase = PH_DONE;
        end
    end

    assign o_res_push = o_q_pop && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WS;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_base  <= '0;
            r_pos   <= '0;
            r_seen  <= 1'b0;
        end else if (o_q_pop) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_pos   <= n_pos;
            r_seen  <= n_seen;
        end
    end

endmodule

// ===== sv/ascii_to_unsigned_parser_unit.sv =====
// Top level of the ASCII to unsigned 64-bit parser: front, queues and parse engine.
//
//  channel   handshake                 payload
//  --------  ------------------------  ----------------------------------------------
//  char in   push / full               i_ch[7:0], i_start_of_string
//  result    empty / pop               o_value[63:0], o_end_offset[15:0],
//                                      o_overflow, o_no_digits
//  config    i_cfg_valid / o_cfg_ready i_cfg_radix[5:0]
//
//  One character per cycle sustained while the result queue has room; the engine's
//  64x6 multiply-add with its overflow test on the accumulator sets that figure. A
//  result enters the result queue at the same edge its character leaves the character
//  queue, so empty drops only once the character has passed both queues' registers.
//  Reset (synchronous, i_rst_n low) empties both queues, sets radix to 10 and
//  puts the engine in whitespace skip. A stalled result side fills the result
//  queue, which stops the engine, which in turn fills the character queue and
//  raises full.
module ascii_to_unsigned_parser_unit #(
    parameter longint unsigned P_MAX_LEN     = acp_pkg::DEF_MAX_LEN,
    parameter int              P_QUEUE_DEPTH = acp_pkg::DEF_QUEUE_DEPTH,
    parameter int              P_RES_DEPTH   = acp_pkg::DEF_RES_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Character transactions
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_ch,
    input  logic        i_start_of_string,
    // Result transactions
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_value,
    output logic [15:0] o_end_offset,
    output logic        o_overflow,
    output logic        o_no_digits,
    // Configuration transactions
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_radix
);
    import acp_pkg::*;

    localparam int CLS_W = $bits(t_cls);
    localparam int RES_W = $bits(t_res);

    logic [5:0] r_radix;
    t_cls       cls_in, cls_out;
    logic       q_push, q_full, q_empty, q_pop;
    t_res       res_in, res_out;
    logic       res_push, res_full;

    // Radix register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_radix <= i_cfg_radix;
        end
    end

    // Classify each character as it is accepted.
    acp_front u_front (
        .i_ch_push         (push),
        .i_ch              (i_ch),
        .i_start_of_string (i_start_of_string),
        .i_q_full          (q_full),
        .o_ch_full         (full),
        .o_q_push          (q_push),
        .o_cls             (cls_in)
    );

    // Decouple the front from the engine.
    acp_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (P_QUEUE_DEPTH)
    ) u_char_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (cls_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (cls_out),
        .o_empty (q_empty)
    );

    // Run the parse; advance only while the result queue has room.
    acp_back #(
        .P_MAX_LEN (P_MAX_LEN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_radix    (r_radix),
        .i_q_empty  (q_empty),
        .i_cls      (cls_out),
        .o_q_pop    (q_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    // Hold finished results until the consumer pops them.
    acp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (P_RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_value      = res_out.value;
    assign o_end_offset = res_out.end_offset;
    assign o_overflow   = res_out.overflow;
    assign o_no_digits  = res_out.no_digits;

endmodule
